### hdl/hspr_pkg.sv
`timescale 1ns / 1ps

package hspr_pkg;

  localparam int unsigned DefBufferDepth = 32;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned IndexW   = 5;
  localparam int unsigned PosW     = 8;
  localparam int unsigned TickW    = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ByteW-1:0] MsgLengthRst    = 8'd16;
  localparam logic [TickW-1:0] TimeoutTicksRst = 16'd100;

  typedef enum logic [ReqW-1:0] {
    REQ_RX_BYTE = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_READ    = 2'd2,
    REQ_POLL    = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_FIRST  = 3'd0,
    CFG_HEADER_SECOND = 3'd1,
    CFG_HEADER_THIRD  = 3'd2,
    CFG_MSG_LENGTH    = 3'd3,
    CFG_TIMEOUT_TICKS = 3'd4
  } cfg_idx_e;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_SECOND = 6'b000010,
    PH_THIRD  = 6'b000100,
    PH_COUNT  = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  // Control from the deframer to the packet store.
  typedef struct packed {
    logic wr_en;    // store a frame byte
    logic rd_en;    // a request is taken: capture read data
    logic rd_req;   // the request is a read of an in-range position
  } st_ctl_t;

endpackage

### hdl/hspr_store.sv
`timescale 1ns / 1ps

module hspr_store #(
  parameter int unsigned BufferDepth = hspr_pkg::DefBufferDepth,
  parameter int unsigned AddrW       = $clog2(BufferDepth)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hspr_pkg::st_ctl_t          ctl_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [hspr_pkg::ByteW-1:0] wr_data_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [hspr_pkg::ByteW-1:0] rd_data_o
);

  logic [hspr_pkg::ByteW-1:0] mem [BufferDepth];
  logic [BufferDepth-1:0]     valid_q;
  logic [hspr_pkg::ByteW-1:0] rd_data_q;
  logic                       rd_hit_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Entries never written read as zero, as after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_hit_q <= ctl_i.rd_req && valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_hit_q ? rd_data_q : '0;

endmodule

### hdl/header_sync_packet_receiver_top.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// in       | input     | in_valid_i / in_stall_o | req_type_i, rx_byte_i, read_index_i
// out      | output    | out_valid_o / out_stall_i | read_data_o, new_packet_o,
//          |           |                        | link_timeout_o, buffer_overrun_o
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each request updates state and registers its result at the edge that takes it, so one
// request per cycle is sustained while the output is not stalled.
// A read returns the store byte through the store's registered read port.
// The input stalls only while a result is held by a stalled output.
// Reset clears all state and the store's valid bits, so the store reads as zero.

module header_sync_packet_receiver_top #(
  parameter int unsigned BufferDepth = hspr_pkg::DefBufferDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hspr_pkg::ReqW-1:0]     req_type_i,
  input  logic [hspr_pkg::ByteW-1:0]    rx_byte_i,
  input  logic [hspr_pkg::IndexW-1:0]   read_index_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hspr_pkg::ByteW-1:0]    read_data_o,
  output logic                          new_packet_o,
  output logic                          link_timeout_o,
  output logic                          buffer_overrun_o,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hspr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hspr_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(BufferDepth);
  localparam logic [hspr_pkg::PosW-1:0] DepthPos = hspr_pkg::PosW'(BufferDepth);

  // Configuration registers
  logic [hspr_pkg::ByteW-1:0] hdr_first_q, hdr_second_q, hdr_third_q, msg_length_q;
  logic [hspr_pkg::TickW-1:0] timeout_ticks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q     <= '0;
      hdr_second_q    <= '0;
      hdr_third_q     <= '0;
      msg_length_q    <= hspr_pkg::MsgLengthRst;
      timeout_ticks_q <= hspr_pkg::TimeoutTicksRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (hspr_pkg::cfg_idx_e'(cfg_index_i))
        hspr_pkg::CFG_HEADER_FIRST:  hdr_first_q     <= cfg_data_i[hspr_pkg::ByteW-1:0];
        hspr_pkg::CFG_HEADER_SECOND: hdr_second_q    <= cfg_data_i[hspr_pkg::ByteW-1:0];
        hspr_pkg::CFG_HEADER_THIRD:  hdr_third_q     <= cfg_data_i[hspr_pkg::ByteW-1:0];
        hspr_pkg::CFG_MSG_LENGTH:    msg_length_q    <= cfg_data_i[hspr_pkg::ByteW-1:0];
        hspr_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake
  logic out_valid_q;
  logic accept;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // State
  hspr_pkg::phase_e           phase_q, phase_d;
  logic [hspr_pkg::PosW-1:0]  pos_q, pos_d;
  logic                       arrived_q, arrived_d;
  logic                       unread_q, unread_d;
  logic [hspr_pkg::TickW-1:0] idle_cnt_q, idle_cnt_d;
  logic                       timeout_q, timeout_d;
  logic                       overrun_q, overrun_d;
  logic                       started_q, started_d;
  logic                       new_packet_q, new_packet_d;

  logic [hspr_pkg::PosW-1:0]  pos_base;
  logic [hspr_pkg::PosW-1:0]  pos_adv;
  logic [hspr_pkg::PosW-1:0]  pos_new;
  logic                       store_byte;
  logic [hspr_pkg::TickW-1:0] idle_cnt_inc;
  logic [hspr_pkg::PosW-1:0]  read_index_ext;
  hspr_pkg::req_e             req;
  hspr_pkg::st_ctl_t          st_ctl;

  assign req = hspr_pkg::req_e'(req_type_i);

  // The idle phase always restarts the frame at position zero.
  assign pos_base = (phase_q == hspr_pkg::PH_IDLE) ? '0 : pos_q;
  assign pos_adv  = pos_base + hspr_pkg::PosW'(1);

  assign idle_cnt_inc = (idle_cnt_q != '1) ? idle_cnt_q + hspr_pkg::TickW'(1) : idle_cnt_q;

  assign read_index_ext = hspr_pkg::PosW'(read_index_i);

  always_comb begin
    phase_d      = phase_q;
    pos_new      = pos_q;
    arrived_d    = arrived_q;
    unread_d     = unread_q;
    idle_cnt_d   = idle_cnt_q;
    timeout_d    = timeout_q;
    overrun_d    = overrun_q;
    started_d    = started_q;
    new_packet_d = 1'b0;
    store_byte   = 1'b0;
    pos_d        = pos_q;

    unique case (req)
      hspr_pkg::REQ_RX_BYTE: begin
        pos_new = pos_base;
        unique case (phase_q)
          hspr_pkg::PH_IDLE: begin
            if (rx_byte_i == hdr_first_q) begin
              store_byte = 1'b1;
              phase_d    = hspr_pkg::PH_SECOND;
            end
          end
          hspr_pkg::PH_SECOND: begin
            if (rx_byte_i == hdr_second_q) begin
              store_byte = 1'b1;
              phase_d    = hspr_pkg::PH_THIRD;
            end else begin
              phase_d = hspr_pkg::PH_IDLE;
            end
          end
          hspr_pkg::PH_THIRD: begin
            if (rx_byte_i == hdr_third_q) begin
              store_byte = 1'b1;
              phase_d    = hspr_pkg::PH_COUNT;
            end else begin
              phase_d = hspr_pkg::PH_IDLE;
            end
          end
          hspr_pkg::PH_COUNT: begin
            store_byte = 1'b1;
            phase_d    = hspr_pkg::PH_DATA;
          end
          hspr_pkg::PH_DATA: begin
            store_byte = 1'b1;
            // Position reaching length minus one; a zero length ends at once.
            if (({1'b0, pos_adv} + 9'd1) >= {1'b0, msg_length_q}) begin
              phase_d = hspr_pkg::PH_DONE;
            end
          end
          hspr_pkg::PH_DONE: begin
            arrived_d = 1'b1;
            phase_d   = hspr_pkg::PH_IDLE;
          end
          default: begin
            phase_d = hspr_pkg::PH_IDLE;
          end
        endcase
        if (store_byte) begin
          pos_new = pos_adv;
        end
        pos_d = pos_new;
        if (pos_new > DepthPos) begin
          pos_d     = '0;
          overrun_d = 1'b1;
        end
      end
      hspr_pkg::REQ_TICK: begin
        if (!started_q) begin
          started_d = 1'b1;
        end else if (arrived_q) begin
          idle_cnt_d = '0;
          timeout_d  = 1'b0;
          arrived_d  = 1'b0;
          unread_d   = 1'b1;
        end else begin
          idle_cnt_d = idle_cnt_inc;
          if (idle_cnt_inc >= timeout_ticks_q) begin
            timeout_d = 1'b1;
          end
        end
      end
      hspr_pkg::REQ_POLL: begin
        new_packet_d = unread_q;
        unread_d     = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= hspr_pkg::PH_IDLE;
      pos_q        <= '0;
      arrived_q    <= 1'b0;
      unread_q     <= 1'b0;
      idle_cnt_q   <= '0;
      timeout_q    <= 1'b0;
      overrun_q    <= 1'b0;
      started_q    <= 1'b0;
      new_packet_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_q      <= phase_d;
        pos_q        <= pos_d;
        arrived_q    <= arrived_d;
        unread_q     <= unread_d;
        idle_cnt_q   <= idle_cnt_d;
        timeout_q    <= timeout_d;
        overrun_q    <= overrun_d;
        started_q    <= started_d;
        new_packet_q <= new_packet_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Packet store
  assign st_ctl.wr_en  = accept && store_byte && (pos_base < DepthPos);
  assign st_ctl.rd_en  = accept;
  assign st_ctl.rd_req = (req == hspr_pkg::REQ_READ) && (read_index_ext < DepthPos);

  hspr_store #(
    .BufferDepth (BufferDepth),
    .AddrW       (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (st_ctl),
    .wr_addr_i (pos_base[AddrW-1:0]),
    .wr_data_i (rx_byte_i),
    .rd_addr_i (read_index_ext[AddrW-1:0]),
    .rd_data_o (read_data_o)
  );

  assign new_packet_o     = new_packet_q;
  assign link_timeout_o   = timeout_q;
  assign buffer_overrun_o = overrun_q;

endmodule
